[hw/rtl/jcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcs_pkg
// Shared types and constants for the JSONC comment stripper.
// ----------------------------------------------------------------------------
package jcs_pkg;

    // Scanner state; code 7 is unused and behaves as normal text
    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_STRING     = 3'd2,
        MODE_ESCAPE     = 3'd3,
        MODE_LINE       = 3'd4,
        MODE_BLOCK      = 3'd5,
        MODE_BLOCK_STAR = 3'd6
    } scan_mode_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } text_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_text;
    } clean_beat_t;

endpackage

[hw/rtl/jsonc_comment_stripper_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsonc_comment_stripper_unit
// Streaming JSONC comment remover: one text byte in, zero to two bytes out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  text    | in        | text_valid / text_ready   | text_data  (text_beat_t)
//  clean   | out       | clean_valid / clean_ready | clean_data (clean_beat_t)
//
//  One text beat is accepted per cycle while the result queue has room for
//  two results; each beat passes through the combinational scanner and is
//  registered into the queue. The output side drains one result per cycle
//  while clean_ready is high, so a run of beats that each yield two results
//  is held back by text_ready. Reset empties the four-entry result queue and
//  returns the scanner to normal text. Output stalls back up into text_ready
//  once fewer than two slots are free.
// ----------------------------------------------------------------------------
module jsonc_comment_stripper_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_ready,
    input  jcs_pkg::text_beat_t  text_data,
    output logic                 clean_valid,
    input  logic                 clean_ready,
    output jcs_pkg::clean_beat_t clean_data
);
    import jcs_pkg::*;

    scan_mode_t  mode_reg;
    scan_mode_t  mode_next;
    scan_mode_t  step_mode;

    clean_beat_t res0;
    clean_beat_t res1;
    logic [1:0]  res_cnt;

    clean_beat_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]        wr_ptr_reg;
    logic [FIFO_AW-1:0]        wr_ptr_next;
    logic [FIFO_AW-1:0]        rd_ptr_reg;
    logic [FIFO_AW-1:0]        rd_ptr_next;
    logic [FIFO_CW-1:0]        fifo_cnt_reg;
    logic [FIFO_CW-1:0]        fifo_cnt_next;

    logic       push;
    logic       pop;
    logic [7:0] c;

    assign c    = text_data.text_byte;
    assign push = text_valid && text_ready;
    assign pop  = clean_valid && clean_ready;

    // ---------------- scanner next state ----------------
    always_comb
    begin
        step_mode = mode_reg;
        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                    step_mode = MODE_LINE;
                else if (c == CH_STAR)
                    step_mode = MODE_BLOCK;
                else if (c == CH_QUOTE)
                    step_mode = MODE_STRING;
                else
                    step_mode = MODE_NORMAL;
            end
            MODE_STRING:
            begin
                if (c == CH_BACKSLASH)
                    step_mode = MODE_ESCAPE;
                else if (c == CH_QUOTE)
                    step_mode = MODE_NORMAL;
            end
            MODE_ESCAPE:
                step_mode = MODE_STRING;
            MODE_LINE:
            begin
                if (c == CH_NEWLINE)
                    step_mode = MODE_NORMAL;
            end
            MODE_BLOCK:
            begin
                if (c == CH_STAR)
                    step_mode = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR:
            begin
                if (c == CH_SLASH)
                    step_mode = MODE_NORMAL;
                else if (c != CH_STAR)
                    step_mode = MODE_BLOCK;
            end
            default:
            begin
                if (c == CH_QUOTE)
                    step_mode = MODE_STRING;
                else if (c == CH_SLASH)
                    step_mode = MODE_SLASH;
                else
                    step_mode = MODE_NORMAL;
            end
        endcase
        mode_next = text_data.final_byte ? MODE_NORMAL : step_mode;
    end

    // ---------------- scanner outputs ----------------
    always_comb
    begin
        res0    = '{out_byte: c,        has_byte: 1'b1, end_of_text: 1'b0};
        res1    = '{out_byte: c,        has_byte: 1'b1, end_of_text: 1'b0};
        res_cnt = 2'd0;
        unique case (mode_reg)
            MODE_SLASH:
            begin
                // held slash released ahead of a non-opener byte
                if (c != CH_SLASH && c != CH_STAR)
                begin
                    res0.out_byte = CH_SLASH;
                    res_cnt       = 2'd2;
                end
            end
            MODE_STRING, MODE_ESCAPE:
                res_cnt = 2'd1;
            MODE_LINE:
            begin
                if (c == CH_NEWLINE)
                    res_cnt = 2'd1;
            end
            MODE_BLOCK, MODE_BLOCK_STAR:
                res_cnt = 2'd0;
            default:
            begin
                if (c != CH_SLASH)
                    res_cnt = 2'd1;
            end
        endcase

        if (text_data.final_byte)
        begin
            // a slash held at end of text is plain text; count is 0 here
            if (step_mode == MODE_SLASH)
            begin
                res0.out_byte = CH_SLASH;
                res_cnt       = 2'd1;
            end
            priority if (res_cnt == 2'd0)
            begin
                res0    = '{out_byte: 8'h00, has_byte: 1'b0, end_of_text: 1'b1};
                res_cnt = 2'd1;
            end
            else if (res_cnt == 2'd1)
                res0.end_of_text = 1'b1;
            else
                res1.end_of_text = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_NORMAL;
        else if (push)
            mode_reg <= mode_next;
    end

    // ---------------- result queue ----------------
    assign text_ready  = fifo_cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign clean_valid = fifo_cnt_reg != '0;
    assign clean_data  = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg;
        if (push)
        begin
            wr_ptr_next   = wr_ptr_reg + FIFO_AW'(res_cnt);
            fifo_cnt_next = fifo_cnt_next + FIFO_CW'(res_cnt);
        end
        if (pop)
        begin
            rd_ptr_next   = rd_ptr_reg + 1'b1;
            fifo_cnt_next = fifo_cnt_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && res_cnt != 2'd0)
            fifo_mem[wr_ptr_reg] <= res0;
        if (push && res_cnt == 2'd2)
            fifo_mem[wr_ptr_reg + 1'b1] <= res1;
    end

`ifndef ASSERT_OFF
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (push && text_data.final_byte) |=> mode_reg == MODE_NORMAL)
        else $error("scanner not back to normal after final beat");

    a_final_yields: assert property (@(posedge clk) disable iff (!rst_n)
        (push && text_data.final_byte && !pop) |=> fifo_cnt_reg > $past(fifo_cnt_reg))
        else $error("final beat produced no result");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_cnt_reg == '0 || fifo_cnt_reg == FIFO_CW'(FIFO_DEPTH))
            |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step with count");
`endif

endmodule
